@@ rtl/core/ptt_pkg.sv @@
// Package for the priority track table: table geometry, operation and
// status codes, request/response payloads and controller/datapath links.
// No dependencies.
`default_nettype none

package ptt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Operation codes carried by a request.
   localparam logic [2:0] OP_LOOKUP = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_DROP   = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_SORT   = 3'd4;

   // Status codes carried by a response.
   localparam logic [1:0] STAT_OK           = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND    = 2'd1;
   localparam logic [1:0] STAT_NOT_INSERTED = 2'd2;
   localparam logic [1:0] STAT_NOT_OCCUPIED = 2'd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] entity_id;
      logic [15:0] weight;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  result_slot;
      logic [4:0]  entry_count;
      logic        evicted_valid;
      logic [15:0] evicted_id;
      logic [3:0]  selected_slot;
      logic        selected_valid;
   } rsp_type;

   // One table entry.
   typedef struct packed {
      logic        occ;
      logic        sel;
      logic        nw;
      logic        nd;
      logic [15:0] id;
      logic [15:0] wt;
   } rec_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_APPLY,
      ST_SORT_LOAD,
      ST_SORT_STEP,
      ST_FINISH,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN,
      CMD_APPLY,
      CMD_SORT_LOAD,
      CMD_SORT_STEP,
      CMD_FINISH
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_sort;
      logic op_table;
      logic cnt_zero;
      logic cnt_small;
      logic scan_last;
      logic step_end;
      logic sort_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/ptt_ctrl.sv @@
// Controller of the priority track table: sequences scan, apply and
// insertion-sort steps and runs both handshakes. Depends on ptt_pkg.
`default_nettype none

module ptt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire ptt_pkg::dp_status_type dp_stat,
   output ptt_pkg::cmd_type            cmd
);

   ptt_pkg::state_type state_ff, state_in;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_valid) state_in = ptt_pkg::ST_START;
         end
         ptt_pkg::ST_START: begin
            priority if (dp_stat.op_sort) begin
               state_in = dp_stat.cnt_small ? ptt_pkg::ST_FINISH : ptt_pkg::ST_SORT_LOAD;
            end else if (dp_stat.op_table) begin
               state_in = dp_stat.cnt_zero ? ptt_pkg::ST_APPLY : ptt_pkg::ST_SCAN;
            end else begin
               state_in = ptt_pkg::ST_FINISH;
            end
         end
         ptt_pkg::ST_SCAN: begin
            if (dp_stat.scan_last) state_in = ptt_pkg::ST_APPLY;
         end
         ptt_pkg::ST_APPLY: begin
            state_in = ptt_pkg::ST_FINISH;
         end
         ptt_pkg::ST_SORT_LOAD: begin
            state_in = ptt_pkg::ST_SORT_STEP;
         end
         ptt_pkg::ST_SORT_STEP: begin
            if (dp_stat.step_end) begin
               state_in = dp_stat.sort_last ? ptt_pkg::ST_FINISH : ptt_pkg::ST_SORT_LOAD;
            end
         end
         ptt_pkg::ST_FINISH: begin
            state_in = ptt_pkg::ST_RESP;
         end
         ptt_pkg::ST_RESP: begin
            if (rsp_ready) state_in = ptt_pkg::ST_IDLE;
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   // Output logic.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = ptt_pkg::CMD_NONE;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = ptt_pkg::CMD_LOAD;
         end
         ptt_pkg::ST_SCAN:      cmd = ptt_pkg::CMD_SCAN;
         ptt_pkg::ST_APPLY:     cmd = ptt_pkg::CMD_APPLY;
         ptt_pkg::ST_SORT_LOAD: cmd = ptt_pkg::CMD_SORT_LOAD;
         ptt_pkg::ST_SORT_STEP: cmd = ptt_pkg::CMD_SORT_STEP;
         ptt_pkg::ST_FINISH:    cmd = ptt_pkg::CMD_FINISH;
         ptt_pkg::ST_RESP:      rsp_valid = 1'b1;
         default:               cmd = ptt_pkg::CMD_NONE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ptt_datapath.sv @@
// Datapath of the priority track table: the entry registers, one scan read
// port, the apply logic for each operation and the response register.
// Depends on ptt_pkg.
`default_nettype none

module ptt_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ptt_pkg::cmd_type cmd,
   input  wire ptt_pkg::req_type req_data,
   output ptt_pkg::dp_status_type dp_stat,
   output ptt_pkg::rsp_type      rsp_data
);

   localparam int D  = ptt_pkg::TABLE_DEPTH;
   localparam int IW = ptt_pkg::IDX_W;
   localparam int CW = ptt_pkg::CNT_W;

   ptt_pkg::rec_type tab_ff [D];
   ptt_pkg::rec_type tab_in [D];
   ptt_pkg::req_type req_ff, req_in;
   ptt_pkg::rec_type r_ff, r_in;
   ptt_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    ins_ff, ins_in;
   logic [IW-1:0]    k_ff, k_in;
   logic [IW-1:0]    hit_ff, hit_in;
   logic [IW-1:0]    dest_ff, dest_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [IW-1:0]    j_ff, j_in;
   logic             found_ff, found_in;
   logic             ev_ff, ev_in;
   logic [15:0]      evid_ff, evid_in;
   logic [1:0]       status_ff, status_in;
   logic [IW-1:0]    rslot_ff, rslot_in;

   logic [IW-1:0]    rd_addr;
   ptt_pkg::rec_type rd_rec;
   logic [19:0]      w11, wt10;
   logic             slot_ok, evict, pre_sel0, t0, less, j_one;
   logic [CW-1:0]    bound, slot_c;
   logic             sel_v;
   logic [IW-1:0]    sel_s;

   // Single read port: scan pointer, sort load index or sort step neighbor.
   always_comb begin
      unique case (cmd)
         ptt_pkg::CMD_SORT_LOAD: rd_addr = i_ff;
         ptt_pkg::CMD_SORT_STEP: rd_addr = j_ff - IW'(1);
         default:                rd_addr = k_ff;
      endcase
   end
   assign rd_rec = tab_ff[rd_addr];

   // Add threshold: entry weight times 11 against new weight times 10.
   assign w11  = ({4'd0, rd_rec.wt} << 3) + ({4'd0, rd_rec.wt} << 1) + {4'd0, rd_rec.wt};
   assign wt10 = ({4'd0, req_ff.weight} << 3) + ({4'd0, req_ff.weight} << 1);

   assign slot_c   = CW'(req_ff.slot);
   assign slot_ok  = slot_c < count_ff;
   assign evict    = count_ff == CW'(D);
   assign bound    = evict ? CW'(D - 1) : count_ff;
   assign pre_sel0 = tab_ff[0].sel | (evict & tab_ff[D-1].sel);
   assign t0       = req_ff.slot == '0;
   assign less     = rd_rec.wt < r_ff.wt;
   assign j_one    = j_ff == IW'(1);

   // Status toward the controller.
   always_comb begin
      dp_stat.op_sort   = req_ff.op == ptt_pkg::OP_SORT;
      dp_stat.op_table  = req_ff.op == ptt_pkg::OP_LOOKUP || req_ff.op == ptt_pkg::OP_ADD ||
                          req_ff.op == ptt_pkg::OP_DROP || req_ff.op == ptt_pkg::OP_UPDATE;
      dp_stat.cnt_zero  = count_ff == '0;
      dp_stat.cnt_small = count_ff < CW'(2);
      dp_stat.scan_last = CW'(k_ff) == count_ff - CW'(1);
      dp_stat.step_end  = !less || j_one;
      dp_stat.sort_last = CW'(i_ff) == count_ff - CW'(1);
   end

   // Lowest slot carrying the selected mark.
   always_comb begin
      sel_v = 1'b0;
      sel_s = '0;
      for (int m = D - 1; m >= 0; m--) begin
         if (tab_ff[m].sel) begin
            sel_v = 1'b1;
            sel_s = IW'(m);
         end
      end
   end

   // Next values of all datapath registers.
   always_comb begin
      for (int m = 0; m < D; m++) tab_in[m] = tab_ff[m];
      req_in    = req_ff;
      r_in      = r_ff;
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      ins_in    = ins_ff;
      k_in      = k_ff;
      hit_in    = hit_ff;
      dest_in   = dest_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      found_in  = found_ff;
      ev_in     = ev_ff;
      evid_in   = evid_ff;
      status_in = status_ff;
      rslot_in  = rslot_ff;

      unique case (cmd)
         // Take the request and clear the per-operation bookkeeping.
         ptt_pkg::CMD_LOAD: begin
            req_in    = req_data;
            k_in      = '0;
            found_in  = 1'b0;
            hit_in    = '0;
            ins_in    = count_ff;
            dest_in   = req_data.slot;
            ev_in     = 1'b0;
            evid_in   = '0;
            status_in = ptt_pkg::STAT_OK;
            rslot_in  = '0;
            i_in      = IW'(1);
         end

         // Visit one occupied entry per cycle.
         ptt_pkg::CMD_SCAN: begin
            k_in = k_ff + IW'(1);
            unique case (req_ff.op)
               ptt_pkg::OP_LOOKUP: begin
                  if (rd_rec.id == req_ff.entity_id) begin
                     found_in = 1'b1;
                     hit_in   = k_ff;
                  end
               end
               ptt_pkg::OP_ADD: begin
                  if (!found_ff && w11 < wt10) begin
                     found_in = 1'b1;
                     ins_in   = CW'(k_ff);
                  end
                  if (k_ff == IW'(D - 1)) evid_in = rd_rec.id;
               end
               ptt_pkg::OP_DROP: begin
                  if (k_ff == req_ff.slot) begin
                     r_in    = rd_rec;
                     evid_in = rd_rec.id;
                  end
               end
               ptt_pkg::OP_UPDATE: begin
                  if (k_ff == req_ff.slot) r_in = rd_rec;
                  if (k_ff == req_ff.slot || rd_rec.wt >= req_ff.weight) dest_in = k_ff;
               end
               default: k_in = k_ff + IW'(1);
            endcase
         end

         // Rewrite the table in one step from neighbors and captured values.
         ptt_pkg::CMD_APPLY: begin
            unique case (req_ff.op)
               ptt_pkg::OP_LOOKUP: begin
                  status_in = found_ff ? ptt_pkg::STAT_OK : ptt_pkg::STAT_NOT_FOUND;
                  rslot_in  = found_ff ? hit_ff : '0;
               end
               ptt_pkg::OP_ADD: begin
                  for (int m = 0; m < D; m++) tab_in[m].nd = 1'b0;
                  if (ins_ff >= CW'(D)) begin
                     status_in = ptt_pkg::STAT_NOT_INSERTED;
                  end else begin
                     for (int m = 0; m < D; m++) begin
                        if (CW'(m) == ins_ff) begin
                           tab_in[m].occ = 1'b1;
                           tab_in[m].sel = (ins_ff == '0) ? pre_sel0 : 1'b0;
                           tab_in[m].nw  = 1'b1;
                           tab_in[m].nd  = 1'b1;
                           tab_in[m].id  = req_ff.entity_id;
                           tab_in[m].wt  = req_ff.weight;
                        end else if (m > 0 && CW'(m) > ins_ff && CW'(m) <= bound) begin
                           tab_in[m]    = tab_ff[(m == 0) ? 0 : m - 1];
                           tab_in[m].nd = 1'b0;
                           if (m == 1) tab_in[m].sel = 1'b0;
                        end else if (m == 0) begin
                           tab_in[m].sel = pre_sel0;
                        end
                     end
                     ev_in    = evict;
                     count_in = evict ? count_ff : count_ff + CW'(1);
                     rslot_in = IW'(ins_ff);
                  end
               end
               ptt_pkg::OP_DROP: begin
                  if (!slot_ok) begin
                     status_in = ptt_pkg::STAT_NOT_OCCUPIED;
                  end else begin
                     for (int m = 0; m < D; m++) begin
                        if (CW'(m) >= slot_c && CW'(m) < count_ff) begin
                           if (m == D - 1) begin
                              tab_in[m] = '0;
                           end else begin
                              tab_in[m]     = tab_ff[(m == D - 1) ? m : m + 1];
                              tab_in[m].sel = tab_ff[(m == D - 1) ? m : m + 1].sel |
                                              ((m == 0) & t0 & tab_ff[0].sel);
                           end
                        end else begin
                           tab_in[m].sel = tab_ff[m].sel |
                                           ((m == 1) & t0 & tab_ff[0].sel) |
                                           ((m == 0) & !t0 & r_ff.sel);
                        end
                     end
                     ev_in    = 1'b1;
                     count_in = count_ff - CW'(1);
                     rslot_in = req_ff.slot;
                  end
               end
               ptt_pkg::OP_UPDATE: begin
                  if (!slot_ok) begin
                     status_in = ptt_pkg::STAT_NOT_OCCUPIED;
                  end else begin
                     for (int m = 0; m < D; m++) begin
                        if (dest_ff == req_ff.slot) begin
                           if (IW'(m) == req_ff.slot) tab_in[m].wt = req_ff.weight;
                        end else if (IW'(m) >= req_ff.slot && IW'(m) < dest_ff) begin
                           tab_in[m] = tab_ff[(m == D - 1) ? m : m + 1];
                           if (m == 0 && r_ff.sel) tab_in[m].sel = 1'b1;
                        end else if (IW'(m) == dest_ff) begin
                           tab_in[m]    = r_ff;
                           tab_in[m].wt = req_ff.weight;
                           if (t0 && r_ff.sel) tab_in[m].sel = 1'b0;
                        end
                     end
                     rslot_in = dest_ff;
                  end
               end
               default: status_in = ptt_pkg::STAT_OK;
            endcase
         end

         // Insertion sort: pick up entry i.
         ptt_pkg::CMD_SORT_LOAD: begin
            r_in = rd_rec;
            j_in = i_ff;
         end

         // Insertion sort: move the held entry up one slot or set it down.
         ptt_pkg::CMD_SORT_STEP: begin
            for (int m = 0; m < D; m++) begin
               if (less) begin
                  if (IW'(m) == j_ff) begin
                     tab_in[m] = rd_rec;
                     if (j_one) tab_in[m].sel = 1'b0;
                  end
                  if (j_one && m == 0) begin
                     tab_in[m]     = r_ff;
                     tab_in[m].sel = r_ff.sel | rd_rec.sel;
                  end
               end else if (IW'(m) == j_ff) begin
                  tab_in[m] = r_ff;
               end
            end
            if (less && !j_one) j_in = j_ff - IW'(1);
            if (!less || j_one) i_in = i_ff + IW'(1);
         end

         // Build the response from the updated table.
         ptt_pkg::CMD_FINISH: begin
            rsp_in.status         = status_ff;
            rsp_in.result_slot    = rslot_ff;
            rsp_in.entry_count    = count_ff;
            rsp_in.evicted_valid  = ev_ff;
            rsp_in.evicted_id     = ev_ff ? evid_ff : '0;
            rsp_in.selected_slot  = sel_s;
            rsp_in.selected_valid = sel_v;
         end

         default: k_in = k_ff;
      endcase
   end

   // Table and count registers; identifiers need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < D; m++) begin
            tab_ff[m].occ <= 1'b0;
            tab_ff[m].sel <= 1'b0;
            tab_ff[m].nw  <= 1'b0;
            tab_ff[m].nd  <= 1'b0;
            tab_ff[m].id  <= tab_in[m].id;
            tab_ff[m].wt  <= '0;
         end
         count_ff <= '0;
      end else begin
         for (int m = 0; m < D; m++) tab_ff[m] <= tab_in[m];
         count_ff <= count_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      r_ff      <= r_in;
      rsp_ff    <= rsp_in;
      ins_ff    <= ins_in;
      k_ff      <= k_in;
      hit_ff    <= hit_in;
      dest_ff   <= dest_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      found_ff  <= found_in;
      ev_ff     <= ev_in;
      evid_ff   <= evid_in;
      status_ff <= status_in;
      rslot_ff  <= rslot_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/priority_track_table.sv @@
// Top level of the priority track table: controller plus datapath.
// Depends on ptt_pkg, ptt_ctrl and ptt_datapath.
//
// A table of up to sixteen tracks kept in descending threat weight. One
// request is taken at a time and yields one response. Lookup, add, drop
// and update read the occupied entries through one read port, one entry
// per cycle, then rewrite the table in one apply step. A full sort is an
// insertion sort over the same read port: each entry is picked up in a
// load step, then moved one slot per cycle until it is set down. Unused
// op codes go straight to the response. The next request is taken once
// the response transfer has completed.
`default_nettype none

module priority_track_table (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ptt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ptt_pkg::rsp_type      rsp_data
);

   ptt_pkg::cmd_type       cmd;
   ptt_pkg::dp_status_type dp_stat;

   // Sequencer.
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // Table and arithmetic.
   ptt_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

   // A response and a new request never share a cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   // The count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 5'(ptt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // An eviction only comes with a successful operation.
   a_evict_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted_valid |-> rsp_data.status == ptt_pkg::STAT_OK)
      else $error("eviction reported with a failing status");

endmodule

`default_nettype wire
